### hdl/differential_drive_odometry_assert.svh
// Assertion macros shared by the odometry RTL.
// Both expect clk and arst_n in scope.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH

// same-cycle implication
`define DDO_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DDO_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/ddo_pkg.sv
package ddo_pkg;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_DIST,
		S_PREP,
		S_MUL2,
		S_ROT
	} state_t;

	// config register map
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_MPT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ITW = 2'd1;
	localparam int ITW_W = 24;
	localparam logic [31:0] MPT_RESET = 32'd42949673;
	localparam logic [ITW_W-1:0] ITW_RESET = 24'd655360;

	// fixed-point constants
	localparam logic [31:0] RAD_TO_BA = 32'd683565276;
	localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
	localparam int GAIN_FRAC = 30;
	localparam int ITW_FRAC = 16;

	// radix-4 Booth multiplier: signed 64-bit multiplicand, unsigned 32-bit multiplier
	localparam int MUL_A_W = 64;
	localparam int MUL_B_W = 32;
	localparam int MUL_DIGITS = (MUL_B_W + 2) / 2;
	localparam int MUL_CNT_W = $clog2(MUL_DIGITS + 1);

	// CORDIC datapath
	localparam int COR_W = 34;
	localparam int ATAN_COUNT = 24;
	localparam int ATAN_IDX_W = $clog2(ATAN_COUNT);

	typedef struct packed {
		logic start;
		logic signed [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic busy;
		logic [MUL_A_W-1:0] p;
	} mul_rsp_t;

	typedef struct packed {
		logic start;
		logic signed [31:0] k;
		logic [31:0] ang;
	} cor_req_t;

	typedef struct packed {
		logic busy;
		logic [31:0] x;
		logic [31:0] y;
	} cor_rsp_t;

	// atan(2^-i) as binary angle, full turn = 2^32
	function automatic logic [31:0] atan_ba(input logic [ATAN_IDX_W-1:0] idx);
		logic [31:0] v;
		unique case (idx)
			5'd0: v = 32'h2000_0000;
			5'd1: v = 32'h12E4_051E;
			5'd2: v = 32'h09FB_385B;
			5'd3: v = 32'h0511_11D4;
			5'd4: v = 32'h028B_0D43;
			5'd5: v = 32'h0145_D7E1;
			5'd6: v = 32'h00A2_F61E;
			5'd7: v = 32'h0051_7C55;
			5'd8: v = 32'h0028_BE53;
			5'd9: v = 32'h0014_5F2F;
			5'd10: v = 32'h000A_2F98;
			5'd11: v = 32'h0005_17CC;
			5'd12: v = 32'h0002_8BE6;
			5'd13: v = 32'h0001_45F3;
			5'd14: v = 32'h0000_A2FA;
			5'd15: v = 32'h0000_517D;
			5'd16: v = 32'h0000_28BE;
			5'd17: v = 32'h0000_145F;
			5'd18: v = 32'h0000_0A30;
			5'd19: v = 32'h0000_0518;
			5'd20: v = 32'h0000_028C;
			5'd21: v = 32'h0000_0146;
			5'd22: v = 32'h0000_00A3;
			5'd23: v = 32'h0000_0051;
			default: v = 32'h0000_0000;
		endcase
		return v;
	endfunction

endpackage

### hdl/differential_drive_odometry.sv
// Differential-drive wheel odometry: encoder totals in, pose (x, y, heading) out.
// Each transaction runs three rounds of multiplies on the 17-digit Booth multipliers,
// the last alongside the CORDIC rotation.
// One item in flight at a time: a new sample is taken only once the last has committed.
// Reset (arst_n low, async): pose and stored totals cleared, registers back to
// 0.01 m/tick and 10 /m, no result pending.
`include "differential_drive_odometry_assert.svh"

module differential_drive_odometry #(
	parameter int FRAC_BITS    = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,

	// config write port
	input  logic                          cfg_we,
	input  logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,

	// encoder sample
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [31:0]            left_count,
	input  logic signed [31:0]            right_count,

	// pose result
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [31:0]            pos_x,
	output logic signed [31:0]            pos_y,
	output logic [31:0]                   heading
);

	// tick * Q0.32 product down to Q.FRAC_BITS metres
	localparam int DIST_SHIFT = 32 - FRAC_BITS;

	// ------------------------------------------------------------------
	// State
	// ------------------------------------------------------------------
	ddo_pkg::state_t           state_q, state_d;

	logic [31:0]               mpt_q;          // metres per tick, Q0.32
	logic [ddo_pkg::ITW_W-1:0] itw_q;          // inverse track width, Q8.16

	logic [31:0]               last_left_q, last_right_q;
	logic [31:0]               pose_x_q, pose_y_q, pose_angle_q;
	logic                      out_valid_q;

	logic signed [63:0]        dl_q, dr_q;     // wheel distances, Q.FRAC_BITS

	// sequencer strobes
	logic                      start_dist;     // input accepted, kick both distance muls
	logic                      latch_dist;     // distances ready
	logic                      start_turn;     // heading-change and gain muls
	logic                      start_rot;      // rad->angle mul plus CORDIC
	logic                      commit;         // update pose, present result

	ddo_pkg::mul_req_t         mul_a_req, mul_b_req;
	ddo_pkg::mul_rsp_t         mul_a_rsp, mul_b_rsp;
	ddo_pkg::cor_req_t         cor_req;
	ddo_pkg::cor_rsp_t         cor_rsp;

	// ------------------------------------------------------------------
	// Datapath glue
	// ------------------------------------------------------------------
	logic [31:0]               delta_l, delta_r;
	logic signed [63:0]        dist_a_l, dist_a_r;
	logic signed [63:0]        dist_sum, dist_half, turn_diff, step_ext, rad;
	logic [31:0]               step_sat;
	logic [31:0]               dang;

	// Tick deltas wrap modulo 2^32; a right total of zero means the base
	// did not move, so both distances are forced to zero.
	assign delta_l  = $unsigned(left_count) - last_left_q;
	assign delta_r  = $unsigned(right_count) - last_right_q;
	assign dist_a_l = (right_count == '0) ? '0 : {{32{delta_l[31]}}, delta_l};
	assign dist_a_r = (right_count == '0) ? '0 : {{32{delta_r[31]}}, delta_r};

	// Forward step = floor mean of the two distances, clamped to 32 bits.
	assign dist_sum  = dl_q + dr_q;
	assign dist_half = dist_sum >>> 1;
	assign turn_diff = dr_q - dl_q;

	always_comb begin
		if ((&dist_half[63:31]) || !(|dist_half[63:31])) begin
			step_sat = dist_half[31:0];
		end else if (dist_half[63]) begin
			step_sat = 32'h8000_0000;
		end else begin
			step_sat = 32'h7FFF_FFFF;
		end
	end

	assign step_ext = {{32{step_sat[31]}}, step_sat};

	// Heading change in radians (Q.FRAC_BITS), then in binary angle.
	assign rad  = $signed(mul_a_rsp.p) >>> ddo_pkg::ITW_FRAC;
	assign dang = mul_a_rsp.p[FRAC_BITS+31:FRAC_BITS];

	// Unit A: left distance, then diff * itw, then rad * 2^32/(2 pi).
	// Unit B: right distance, then step * CORDIC gain.
	always_comb begin
		mul_a_req.start = start_dist | start_turn | start_rot;
		mul_b_req.start = start_dist | start_turn;
		if (start_dist) begin
			mul_a_req.a = dist_a_l;
			mul_a_req.b = mpt_q;
			mul_b_req.a = dist_a_r;
			mul_b_req.b = mpt_q;
		end else if (start_turn) begin
			mul_a_req.a = turn_diff;
			mul_a_req.b = {{(32-ddo_pkg::ITW_W){1'b0}}, itw_q};
			mul_b_req.a = step_ext;
			mul_b_req.b = ddo_pkg::CORDIC_GAIN;
		end else begin
			mul_a_req.a = rad;
			mul_a_req.b = ddo_pkg::RAD_TO_BA;
			mul_b_req.a = step_ext;
			mul_b_req.b = ddo_pkg::CORDIC_GAIN;
		end
	end

	// CORDIC rotates the gain-scaled step by the heading held before this item.
	assign cor_req.start = start_rot;
	assign cor_req.k     = $signed(mul_b_rsp.p[ddo_pkg::GAIN_FRAC+31:ddo_pkg::GAIN_FRAC]);
	assign cor_req.ang   = pose_angle_q;

	ddo_mul u_mul_a (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_a_req),
		.rsp    (mul_a_rsp)
	);

	ddo_mul u_mul_b (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_b_req),
		.rsp    (mul_b_rsp)
	);

	ddo_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cor_req),
		.rsp    (cor_rsp)
	);

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ddo_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		start_dist = 1'b0;
		latch_dist = 1'b0;
		start_turn = 1'b0;
		start_rot  = 1'b0;
		commit     = 1'b0;
		unique case (state_q)
			ddo_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					start_dist = 1'b1;
					state_d    = ddo_pkg::S_DIST;
				end
			end
			ddo_pkg::S_DIST: begin
				if (!mul_a_rsp.busy && !mul_b_rsp.busy) begin
					latch_dist = 1'b1;
					state_d    = ddo_pkg::S_PREP;
				end
			end
			ddo_pkg::S_PREP: begin
				start_turn = 1'b1;
				state_d    = ddo_pkg::S_MUL2;
			end
			ddo_pkg::S_MUL2: begin
				if (!mul_a_rsp.busy && !mul_b_rsp.busy) begin
					start_rot = 1'b1;
					state_d   = ddo_pkg::S_ROT;
				end
			end
			ddo_pkg::S_ROT: begin
				// wait for both units and a free output slot
				if (!mul_a_rsp.busy && !cor_rsp.busy && (!out_valid_q || out_ready)) begin
					commit  = 1'b1;
					state_d = ddo_pkg::S_IDLE;
				end
			end
			default: state_d = ddo_pkg::S_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mpt_q <= ddo_pkg::MPT_RESET;
			itw_q <= ddo_pkg::ITW_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ddo_pkg::REG_MPT: mpt_q <= cfg_data;
				ddo_pkg::REG_ITW: itw_q <= cfg_data[ddo_pkg::ITW_W-1:0];
				default: ;
			endcase
		end
	end

	// Stored totals follow every sample, moving or not.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_left_q  <= '0;
			last_right_q <= '0;
		end else if (start_dist) begin
			last_left_q  <= $unsigned(left_count);
			last_right_q <= $unsigned(right_count);
		end
	end

	always_ff @(posedge clk) begin
		if (latch_dist) begin
			dl_q <= $signed(mul_a_rsp.p) >>> DIST_SHIFT;
			dr_q <= $signed(mul_b_rsp.p) >>> DIST_SHIFT;
		end
	end

	// Pose registers double as the output holding register: they only move
	// on commit, which waits until the previous result has been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_x_q     <= '0;
			pose_y_q     <= '0;
			pose_angle_q <= '0;
		end else if (commit) begin
			pose_x_q     <= pose_x_q + cor_rsp.x;
			pose_y_q     <= pose_y_q + cor_rsp.y;
			pose_angle_q <= pose_angle_q + dang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x     = $signed(pose_x_q);
	assign pos_y     = $signed(pose_y_q);
	assign heading   = pose_angle_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`DDO_ASSERT_IMP(a_accept_units_idle, in_valid && in_ready, !mul_a_rsp.busy && !mul_b_rsp.busy && !cor_rsp.busy, "transaction accepted while a unit is busy")
	`DDO_ASSERT_IMP(a_mul_lockstep, state_q == ddo_pkg::S_DIST || state_q == ddo_pkg::S_MUL2, mul_a_rsp.busy == mul_b_rsp.busy, "multipliers out of step")
	`DDO_ASSERT_NXT(a_pose_hold, !commit, $stable(pose_x_q) && $stable(pose_y_q) && $stable(pose_angle_q), "pose moved without commit")
	`DDO_ASSERT_NXT(a_commit_valid, commit, out_valid_q, "commit did not present a result")

endmodule

### hdl/ddo_mul.sv
// Radix-4 Booth shift-add multiplier, two multiplier bits per cycle.
// Product is a * b modulo 2^64.
module ddo_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  ddo_pkg::mul_req_t req,
	output ddo_pkg::mul_rsp_t rsp
);

	logic [ddo_pkg::MUL_CNT_W-1:0] cnt_q;
	logic [ddo_pkg::MUL_A_W-1:0]   acc_q;
	logic [ddo_pkg::MUL_A_W-1:0]   a_q;
	logic [ddo_pkg::MUL_B_W+1:0]   b_q;
	logic                          prev_q;

	logic                          busy;
	logic                          dig_zero, dig_two, dig_neg;
	logic [ddo_pkg::MUL_A_W-1:0]   addend;
	logic [ddo_pkg::MUL_A_W-1:0]   acc_next;

	assign busy = (cnt_q != '0);

	always_comb begin
		dig_zero = 1'b0;
		dig_two  = 1'b0;
		dig_neg  = 1'b0;
		unique case ({b_q[1:0], prev_q}) inside
			3'b000, 3'b111: dig_zero = 1'b1;
			3'b001, 3'b010: ;
			3'b011: dig_two = 1'b1;
			3'b100: begin
				dig_two = 1'b1;
				dig_neg = 1'b1;
			end
			3'b101, 3'b110: dig_neg = 1'b1;
			default: dig_zero = 1'b1;
		endcase
		if (dig_zero) begin
			addend = '0;
		end else if (dig_two) begin
			addend = a_q << 1;
		end else begin
			addend = a_q;
		end
		acc_next = dig_neg ? (acc_q - addend) : (acc_q + addend);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= ddo_pkg::MUL_CNT_W'(ddo_pkg::MUL_DIGITS);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q  <= '0;
			a_q    <= req.a;
			b_q    <= {2'b00, req.b};
			prev_q <= 1'b0;
		end else if (busy) begin
			acc_q  <= acc_next;
			a_q    <= a_q << 2;
			b_q    <= b_q >> 2;
			prev_q <= b_q[1];
		end
	end

	assign rsp.busy = busy;
	assign rsp.p    = acc_q;

endmodule

### hdl/ddo_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Quadrant is folded in exactly at load; k arrives gain-compensated.
module ddo_cordic #(
	parameter int STEPS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ddo_pkg::cor_req_t req,
	output ddo_pkg::cor_rsp_t rsp
);

	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

	logic                                busy_q;
	logic [ddo_pkg::ATAN_IDX_W-1:0]      cnt_q;
	logic signed [ddo_pkg::COR_W-1:0]    x_q, y_q, z_q;

	logic [31:0]                         ang_rot;
	logic [1:0]                          quad;
	logic [31:0]                         resid;
	logic signed [ddo_pkg::COR_W-1:0]    k_ext, k_neg, x0, y0, z0;
	logic signed [ddo_pkg::COR_W-1:0]    sx, sy, at;

	always_comb begin
		ang_rot = req.ang + QUARTER_TURN;
		quad    = ang_rot[31:30];
		resid   = req.ang - {quad, 30'b0};
		z0      = {{(ddo_pkg::COR_W-32){resid[31]}}, resid};
		k_ext   = {{(ddo_pkg::COR_W-32){req.k[31]}}, req.k};
		k_neg   = -k_ext;
		x0      = quad[0] ? '0 : (quad[1] ? k_neg : k_ext);
		y0      = quad[0] ? (quad[1] ? k_neg : k_ext) : '0;
		sx      = y_q >>> cnt_q;
		sy      = x_q >>> cnt_q;
		at      = {{(ddo_pkg::COR_W-32){1'b0}}, ddo_pkg::atan_ba(cnt_q)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			busy_q <= (cnt_q != ddo_pkg::ATAN_IDX_W'(STEPS - 1));
			cnt_q  <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= z0;
		end else if (busy_q) begin
			if (!z_q[ddo_pkg::COR_W-1]) begin
				x_q <= x_q - sx;
				y_q <= y_q + sy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + sx;
				y_q <= y_q - sy;
				z_q <= z_q + at;
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.x    = x_q[31:0];
	assign rsp.y    = y_q[31:0];

endmodule

### tb/tb.sv
module tb;

	localparam int FRAC_BITS      = 16;
	localparam int CORDIC_STEPS   = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 64;

	localparam logic [31:0] MPT_AT_RESET = 32'd42949673;
	localparam logic [23:0] ITW_AT_RESET = 24'd655360;
	localparam longint BA_PER_RAD = 64'sd683565276;
	localparam longint ROT_GAIN   = 64'sd652032874;
	localparam longint STEP_MAX   = 64'sd2147483647;
	localparam longint STEP_MIN   = -64'sd2147483648;

	// indexes past the register map, writes there must be dropped
	localparam logic [ddo_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [ddo_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [31:0]        hdg;
	} pose_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] left_count = '0;
	logic signed [31:0] right_count = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic [31:0] heading;

	// binary-angle arctangent of 2^-i
	logic [31:0] atan_turn [0:23] = '{
		32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
		32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
		32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
		32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
		32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
		32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
	};

	// predicted registers and odometry state
	logic [31:0] odo_mpt = MPT_AT_RESET;
	logic [23:0] odo_itw = ITW_AT_RESET;
	logic [31:0] odo_last_l = '0;
	logic [31:0] odo_last_r = '0;
	logic [31:0] odo_x = '0;
	logic [31:0] odo_y = '0;
	logic [31:0] odo_ang = '0;

	pose_t pose_q [$];
	logic [31:0] track_left = '0;
	logic [31:0] track_right = '0;
	bit no_idle = 1'b0;
	int err_count = 0;
	int stall_cycles = 0;
	int rdy_hold = 0;

	differential_drive_odometry #(
		.FRAC_BITS   (FRAC_BITS),
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.left_count (left_count),
		.right_count(right_count),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.heading    (heading)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// gain-compensated step rotated by the heading, quadrant first, then shift-add stages
	function automatic void cordic_rotate(input longint s, input logic [31:0] ang,
			output longint ox, output longint oy);
		longint k, x, y, z, dx, dy;
		logic [31:0] turned, resid;
		logic [1:0] quad;
		k = (s * ROT_GAIN) >>> 30;
		turned = ang + 32'h4000_0000;
		quad = turned[31:30];
		resid = ang - {quad, 30'd0};
		z = longint'($signed(resid));
		case (quad)
			2'd0: begin x = k; y = 0; end
			2'd1: begin x = 0; y = k; end
			2'd2: begin x = -k; y = 0; end
			default: begin x = 0; y = -k; end
		endcase
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= longint'(atan_turn[i]);
			end else begin
				x += dx;
				y -= dy;
				z += longint'(atan_turn[i]);
			end
		end
		ox = x;
		oy = y;
	endfunction

	function automatic pose_t advance_pose(input logic [31:0] l, input logic [31:0] r);
		longint dl, dr, stp, diff, rad, dang, mx, my;
		logic [31:0] ticks_l, ticks_r;
		dl = 0;
		dr = 0;
		ticks_l = l - odo_last_l;
		ticks_r = r - odo_last_r;
		// a zero right total means the base did not move
		if (r != 0) begin
			dl = (longint'($signed(ticks_l)) * longint'(odo_mpt)) >>> (32 - FRAC_BITS);
			dr = (longint'($signed(ticks_r)) * longint'(odo_mpt)) >>> (32 - FRAC_BITS);
		end
		odo_last_l = l;
		odo_last_r = r;
		stp = (dl + dr) >>> 1;
		if (stp > STEP_MAX)
			stp = STEP_MAX;
		if (stp < STEP_MIN)
			stp = STEP_MIN;
		diff = dr - dl;
		rad = (diff * longint'(odo_itw)) >>> 16;
		dang = (rad * BA_PER_RAD) >>> FRAC_BITS;
		// position moves along the heading held before this sample
		if (stp != 0) begin
			cordic_rotate(stp, odo_ang, mx, my);
			odo_x += mx[31:0];
			odo_y += my[31:0];
		end
		odo_ang += dang[31:0];
		return '{x: odo_x, y: odo_y, hdg: odo_ang};
	endfunction

	function automatic void report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		err_count++;
		$display("%0t: %s expected %h, got %h", $time, what, want, got);
	endfunction

	// sender: random idle gaps, occasionally a long one, none while no_idle is set
	task automatic send_sample(input logic [31:0] l, input logic [31:0] r);
		int gap;
		gap = 0;
		if (!no_idle) begin
			while ($urandom_range(99) < 26)
				gap++;
			if ($urandom_range(99) < 4)
				gap += $urandom_range(70, 1);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		left_count <= l;
		right_count <= r;
		do @(posedge clk); while (!in_ready);
		pose_q.push_back(advance_pose(l, r));
	endtask

	task automatic await_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pose_q.size() != 0);
	endtask

	// both registers plus one write to an unmapped index
	task automatic set_config(input logic [31:0] mpt, input logic [23:0] itw);
		logic [7:0] junk;
		junk = 8'($urandom);
		cfg_we <= 1'b1;
		cfg_index <= ddo_pkg::REG_MPT;
		cfg_data <= mpt;
		@(posedge clk);
		cfg_index <= ddo_pkg::REG_ITW;
		cfg_data <= {junk, itw};
		@(posedge clk);
		cfg_index <= $urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO;
		cfg_data <= $urandom;
		@(posedge clk);
		cfg_we <= 1'b0;
		odo_mpt = mpt;
		odo_itw = itw;
	endtask

	// mostly smooth encoder tracks, some right-zero samples and some noise
	task automatic next_sample(output logic [31:0] l, output logic [31:0] r);
		int unsigned pick;
		logic [31:0] span, step_l, step_r;
		pick = $urandom_range(99);
		span = ($urandom_range(9) == 0) ? 32'h00FF_FFFF : 32'd600;
		step_l = $urandom_range(2 * span) - span;
		step_r = ($urandom_range(3) == 0) ? step_l : $urandom_range(2 * span) - span;
		if (pick < 85) begin
			track_left += step_l;
			track_right += step_r;
		end else if (pick < 92) begin
			track_left += step_l;
			track_right = '0;
		end else begin
			track_left = $urandom;
			track_right = $urandom;
		end
		l = track_left;
		r = track_right;
	endtask

	task automatic test_reset_values();
		send_sample(32'd0, 32'd0);
		send_sample(32'd100, 32'd100);
		send_sample(32'd150, 32'd250);
		send_sample(-32'sd5, 32'd0);
		send_sample(-32'sd5, 32'd1);
		send_sample(32'h7FFF_FFFF, 32'h8000_0000);
		send_sample(32'h8000_0000, 32'h7FFF_FFFF);
		send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);
	endtask

	task automatic test_register_extremes();
		await_results();
		set_config(32'hFFFF_FFFF, 24'hFF_FFFF);
		send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_sample(32'h0000_0000, 32'h8000_0001);
		send_sample(32'h4000_0000, 32'h4000_0000);
		send_sample(32'h4000_1000, 32'h4000_1000);
		send_sample(32'h4000_1000, 32'h4000_0FFF);
		await_results();
		set_config(32'd1, 24'd1);
		send_sample(32'h4000_1010, 32'h4000_1010);
		send_sample(32'h7000_0000, 32'h7000_0000);
		send_sample(32'h7000_0001, 32'h6FFF_0000);
		await_results();
		set_config(32'd0, 24'd0);
		send_sample(32'h1234_5678, 32'h8765_4321);
		send_sample(32'h0000_0000, 32'hFFFF_0000);
		await_results();
		set_config(32'd0, 24'hFF_FFFF);
		send_sample(32'h0001_0000, 32'h0000_0001);
	endtask

	task automatic test_steady_stream();
		logic [31:0] l, r;
		await_results();
		no_idle = 1'b1;
		set_config($urandom_range(32'h0400_0000, 32'h0001_0000),
			24'($urandom_range(24'h10_0000, 24'h00_4000)));
		repeat (150) begin
			next_sample(l, r);
			send_sample(l, r);
		end
		await_results();
		no_idle = 1'b0;
	endtask

	task automatic test_random_tracks();
		logic [31:0] l, r;
		for (int ph = 0; ph < 5; ph++) begin
			await_results();
			case (ph)
				0: set_config(MPT_AT_RESET, ITW_AT_RESET);
				1: set_config($urandom_range(32'h1000_0000, 32'h0010_0000),
					24'($urandom_range(24'h40_0000, 24'h00_4000)));
				2: set_config(32'hFFFF_FFFF, 24'hFF_FFFF);
				3: set_config(32'd1, 24'd1);
				default: set_config($urandom, 24'($urandom));
			endcase
			repeat (160) begin
				if ($urandom_range(99) == 0)
					await_results();
				next_sample(l, r);
				send_sample(l, r);
			end
		end
	endtask

	// receiver: random stalls, some long, none while no_idle is set
	always @(posedge clk) begin
		if (no_idle) begin
			out_ready <= 1'b1;
			rdy_hold <= 0;
		end else if (rdy_hold > 0) begin
			out_ready <= 1'b0;
			rdy_hold <= rdy_hold - 1;
		end else if ($urandom_range(99) < 3) begin
			out_ready <= 1'b0;
			rdy_hold <= $urandom_range(60, 1);
		end else begin
			out_ready <= ($urandom_range(99) >= 26);
		end
	end

	always @(posedge clk) begin
		pose_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pose_q.size() == 0) begin
				err_count++;
				$display("%0t: result expected none, got x=%h y=%h heading=%h",
					$time, pos_x, pos_y, heading);
			end else begin
				want = pose_q.pop_front();
				if (want.x !== pos_x)
					report_mismatch("pos_x", want.x, pos_x);
				if (want.y !== pos_y)
					report_mismatch("pos_y", want.y, pos_y);
				if (want.hdg !== heading)
					report_mismatch("heading", want.hdg, heading);
			end
		end
	end

	// cycles since the last transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_register_extremes();
		test_steady_stream();
		test_random_tracks();
		await_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0 && pose_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
